/* hdl/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg - shared definitions for the LZ77 window decoder
// Field widths, parameter defaults, item kind codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 32768;
    localparam int MAX_COPY_DEF     = 64;

    localparam int CFG_W      = 16;
    localparam int LITERAL_W  = 8;
    localparam int COPY_LEN_W = 7;
    localparam int DISTANCE_W = 15;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 16'd32768;

    localparam logic OP_LITERAL = 1'b0;
    localparam logic OP_PAIR    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LIT  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_READ = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;     // latch input fields, fix write position
        logic emit_lit;   // store literal, load output register
        logic prep;       // compute copy source position
        logic rd;         // read history at source position
        logic emit_copy;  // store copied byte, load output register
    } cmd_t;

    typedef struct packed {
        logic in_is_pair;
        logic in_zero_len;
        logic out_free;
        logic last_byte;
    } status_t;

endpackage

/* hdl/lzwd_ctrl.sv */
// ----------------------------------------------------------------------------
// lzwd_ctrl - sequencer of the LZ77 window decoder
// One-hot state machine stepping a literal or a copy through the datapath.
// ----------------------------------------------------------------------------
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.in_is_pair)
                    begin
                        state_next = ST_LIT;
                    end
                    else if (!status.in_zero_len)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_LIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_lit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_copy = 1'b1;
                    state_next    = status.last_byte ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/lzwd_dp.sv */
// ----------------------------------------------------------------------------
// lzwd_dp - datapath of the LZ77 window decoder
// History memory, write and source positions, copy counter, window length
// register and the output register.
// ----------------------------------------------------------------------------
module lzwd_dp
    import lzwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int MAX_COPY     = MAX_COPY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  op,
    input  logic [LITERAL_W-1:0]  literal,
    input  logic [COPY_LEN_W-1:0] copy_len,
    input  logic [DISTANCE_W-1:0] distance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LITERAL_W-1:0]  out_byte,
    output logic                  last,
    input  cmd_t                  cmd,
    output status_t               status
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = $clog2(MAX_COPY + 1);

    logic [LITERAL_W-1:0] mem [WINDOW_DEPTH];

    logic [CFG_W-1:0]     len_cfg_reg;
    logic [AW-1:0]        wpos_reg;
    logic [AW-1:0]        src_reg;
    logic [LW-1:0]        back_reg;
    logic [CW-1:0]        cnt_reg;
    logic [LITERAL_W-1:0] lit_reg;
    logic [LITERAL_W-1:0] rd_data_reg;
    logic [LITERAL_W-1:0] out_byte_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    logic [LW-1:0]        eff_len;
    logic [AW-1:0]        wpos_fix;
    logic [LW-1:0]        back_in;
    logic [CW-1:0]        cnt_in;
    logic [LW:0]          src_sum;
    logic [AW-1:0]        src_start;
    logic [LW-1:0]        wpos_inc;
    logic [LW-1:0]        src_inc;
    logic [AW-1:0]        wpos_adv;
    logic [AW-1:0]        src_adv;
    logic                 mem_we;
    logic [LITERAL_W-1:0] mem_wdata;

    // 0 acts as 1, anything above the depth acts as the depth
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (32'(len_cfg_reg) > 32'(WINDOW_DEPTH))
        begin
            eff_len = LW'(WINDOW_DEPTH);
        end
        else
        begin
            eff_len = LW'(len_cfg_reg);
        end
    end

    assign wpos_fix = (LW'(wpos_reg) >= eff_len) ? '0 : wpos_reg;

    // len - 1 - distance, distance saturated to len - 1
    assign back_in = (32'(distance) >= 32'(eff_len)) ? '0
                   : LW'(32'(eff_len) - 32'd1 - 32'(distance));

    assign cnt_in = (32'(copy_len) > 32'(MAX_COPY)) ? CW'(MAX_COPY) : CW'(copy_len);

    assign src_sum   = (LW+1)'(wpos_reg) + (LW+1)'(back_reg);
    assign src_start = (src_sum >= (LW+1)'(eff_len))
                     ? AW'(src_sum - (LW+1)'(eff_len)) : AW'(src_sum);

    assign wpos_inc = LW'(wpos_reg) + LW'(1);
    assign src_inc  = LW'(src_reg) + LW'(1);
    assign wpos_adv = (wpos_inc >= eff_len) ? '0 : wpos_inc[AW-1:0];
    assign src_adv  = (src_inc >= eff_len) ? '0 : src_inc[AW-1:0];

    assign mem_we    = cmd.emit_lit | cmd.emit_copy;
    assign mem_wdata = cmd.emit_lit ? lit_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wpos_reg] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[src_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= WINDOW_LEN_RST;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_cfg_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                wpos_reg <= wpos_fix;
            end
            else if (mem_we)
            begin
                wpos_reg <= wpos_adv;
            end
            if (mem_we)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lit_reg  <= literal;
            back_reg <= back_in;
            cnt_reg  <= cnt_in;
        end
        if (cmd.prep)
        begin
            src_reg <= src_start;
        end
        else if (cmd.emit_copy)
        begin
            src_reg <= src_adv;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (mem_we)
        begin
            out_byte_reg <= mem_wdata;
            out_last_reg <= cmd.emit_lit | (cnt_reg == CW'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

    assign status.in_is_pair  = (op == OP_PAIR);
    assign status.in_zero_len = (copy_len == '0);
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.last_byte   = (cnt_reg == CW'(1));

endmodule

/* hdl/lz77_window_decoder.sv */
// ----------------------------------------------------------------------------
// lz77_window_decoder - history window of an LZ77 decompressor
// Takes literals and length/distance pairs, emits decoded bytes one at a time
// on the output channel, last byte of each item flagged.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | dir | handshake
//  ---------+---------------------------------------+-----+------------------
//  config   | cfg_we, cfg_data (window_len)         | in  | write on cfg_we
//  input    | op, literal, copy_len, distance       | in  | in_valid/in_stall
//  output   | out_byte, last                        | out | out_valid/out_stall
//
//  Steps: a literal is accepted, then stored and emitted. A pair is accepted,
//  its source set up, then each copied byte (copy length after saturation) is
//  one history read and one write-back/emit on the single-port history memory.
//  A zero-length pair emits no byte. One input request is worked on at a time.
//  Reset: write position 0, window length 32768, output empty; the history
//  is not cleared and needs no clearing pass.
//  Stalls: out_stall holds the sequencer in its emit step while the output
//  register is full; earlier steps go on while the previous byte waits.
//
module lz77_window_decoder
    import lzwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int MAX_COPY     = MAX_COPY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [LITERAL_W-1:0]  literal,
    input  logic [COPY_LEN_W-1:0] copy_len,
    input  logic [DISTANCE_W-1:0] distance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LITERAL_W-1:0]  out_byte,
    output logic                  last
);

    cmd_t    cmd;
    status_t status;

    // sequencer: idle/accept, literal emit, source setup, read, copy emit
    lzwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // history memory, positions, counter and output register
    lzwd_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_COPY     (MAX_COPY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .op        (op),
        .literal   (literal),
        .copy_len  (copy_len),
        .distance  (distance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
